// File: hw/rtl/cvae_pkg.sv
// Shared types, constants and codes of the voice allocator and envelope unit.
package cvae_pkg;

    // Default sizes handed to the top level parameters
    localparam int VOICE_COUNT_DEF = 64;
    localparam int CART_COUNT_DEF  = 64;
    localparam int FRAME_BITS_DEF  = 24;

    // Fixed field widths of the stream items
    localparam int CMD_W          = 3;
    localparam int CART_FIELD_W   = 6;
    localparam int VOICE_FIELD_W  = 6;
    localparam int LEN_FIELD_W    = 24;
    localparam int POS_FIELD_W    = 24;
    localparam int WEIGHT_W       = 24;
    localparam int S_TDATA_W      = 56;
    localparam int M_TDATA_W      = 64;
    localparam int M_TDATA_USED_W = 2 * VOICE_FIELD_W + POS_FIELD_W + WEIGHT_W;

    // Envelope Q1.23, gain Q4.20, gain smoothing state
    localparam int ENV_W   = 24;
    localparam int GAIN_W  = 24;
    localparam int GSTEP_W = 25;
    localparam int GCD_W   = 16;
    localparam int RF_W    = 16;
    localparam int PROD_W  = ENV_W + GAIN_W;
    localparam int ENV_FRAC = 23;
    localparam logic [ENV_W-1:0]  ENV_ONE  = 24'h800000;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h100000;

    // Result count per tick
    localparam int N_W = 7;
    localparam logic [N_W-1:0] MAX_REPORTS = 7'd64;

    // Iterative divider
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = 5;

    // Configuration port
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_ENVELOPE_STEP    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_FRAMES   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_RAMP_FRAMES = 2'd2;
    localparam logic [ENV_W-1:0] ENVELOPE_STEP_RST    = 24'd17476;
    localparam logic [RF_W-1:0]  RELEASE_FRAMES_RST   = 16'd480;
    localparam logic [GCD_W-1:0] GAIN_RAMP_FRAMES_RST = 16'd960;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLAY     = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_STOP_ALL = 3'd2,
        CMD_FLUSH    = 3'd3,
        CMD_TICK     = 3'd4,
        CMD_SET_CART = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_VREAD,
        ST_CREAD,
        ST_RELEASE,
        ST_EVAL,
        ST_ROUTE,
        ST_FADE_WAIT,
        ST_GAIN_ROUTE,
        ST_GAIN_WAIT,
        ST_ENV,
        ST_MUL,
        ST_EMIT,
        ST_TICK_END,
        ST_PLAY_CART,
        ST_PLAY_START
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic set_cart;
        logic flush;
        logic idx_clr;
        logic idx_inc;
        logic vscan;
        logic sel_cmd_cart;
        logic rel_write;
        logic eval;
        logic retire;
        logic fade_start;
        logic fade_done;
        logic gain_start;
        logic gain_done;
        logic env_step;
        logic mul;
        logic emit;
        logic writeback;
        logic out_last;
        logic tick_clr;
        logic play_start;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      cart_ok;
        logic      active_cur;
        logic      idx_last;
        logic      rel_hit;
        logic      w_retire;
        logic      w_fade;
        logic      w_gdiv;
        logic      env_retire;
        logic      div_done;
        logic      emit_ok;
        logic      pend_valid;
        logic      out_free;
    } dp_stat_t;

endpackage

// File: hw/rtl/cvae_div.sv
// Restoring divider, one quotient bit per cycle.
module cvae_div import cvae_pkg::*; #(
    parameter int DIVISOR_W = FRAME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    // Step counter and completion flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                done_reg <= 1'b1;
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/cvae_ctrl.sv
// Command sequencer: walks the voice table for play (valid cart), stop, stop all and tick.
module cvae_ctrl import cvae_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t sts,
    output dp_cmd_t  ctl
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath commands
    always_comb
    begin
        ctrl_state_t after_walk;
        ctrl_state_t after_voice;

        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;

        // where to go once the last voice is done
        unique case (sts.cmd)
            CMD_TICK: after_walk = ST_TICK_END;
            CMD_PLAY: after_walk = ST_PLAY_CART;
            default:  after_walk = ST_IDLE;
        endcase
        after_voice = sts.idx_last ? after_walk : ST_VREAD;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    ctl.take   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (sts.cmd)
                    CMD_PLAY:
                    begin
                        if (sts.cart_ok)
                        begin
                            ctl.idx_clr = 1'b1;
                            state_next  = ST_VREAD;
                        end
                    end
                    CMD_STOP, CMD_STOP_ALL:
                    begin
                        ctl.idx_clr = 1'b1;
                        state_next  = ST_VREAD;
                    end
                    CMD_FLUSH:
                        ctl.flush = 1'b1;
                    CMD_TICK:
                    begin
                        ctl.idx_clr  = 1'b1;
                        ctl.tick_clr = 1'b1;
                        state_next   = ST_VREAD;
                    end
                    CMD_SET_CART:
                        ctl.set_cart = sts.cart_ok;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_VREAD:
            begin
                ctl.vscan = 1'b1;
                if (sts.active_cur)
                    state_next = ST_CREAD;
                else
                begin
                    ctl.idx_inc = !sts.idx_last;
                    state_next  = after_voice;
                end
            end
            ST_CREAD:
                state_next = (sts.cmd == CMD_TICK) ? ST_EVAL : ST_RELEASE;
            ST_RELEASE:
            begin
                ctl.rel_write = sts.rel_hit;
                ctl.idx_inc   = !sts.idx_last;
                state_next    = after_voice;
            end
            ST_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                priority if (sts.w_retire)
                begin
                    ctl.retire  = 1'b1;
                    ctl.idx_inc = !sts.idx_last;
                    state_next  = after_voice;
                end
                else if (sts.w_fade)
                begin
                    ctl.fade_start = 1'b1;
                    state_next     = ST_FADE_WAIT;
                end
                else
                    state_next = ST_GAIN_ROUTE;
            end
            ST_FADE_WAIT:
            begin
                if (sts.div_done)
                begin
                    ctl.fade_done = 1'b1;
                    state_next    = ST_GAIN_ROUTE;
                end
            end
            ST_GAIN_ROUTE:
            begin
                if (sts.w_gdiv)
                begin
                    ctl.gain_start = 1'b1;
                    state_next     = ST_GAIN_WAIT;
                end
                else
                    state_next = ST_ENV;
            end
            ST_GAIN_WAIT:
            begin
                if (sts.div_done)
                begin
                    ctl.gain_done = 1'b1;
                    state_next    = ST_ENV;
                end
            end
            ST_ENV:
            begin
                if (sts.env_retire)
                begin
                    ctl.retire  = 1'b1;
                    ctl.idx_inc = !sts.idx_last;
                    state_next  = after_voice;
                end
                else
                begin
                    ctl.env_step = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output slot can take the pending result
                if (sts.emit_ok)
                begin
                    ctl.emit      = 1'b1;
                    ctl.writeback = 1'b1;
                    ctl.idx_inc   = !sts.idx_last;
                    state_next    = after_voice;
                end
            end
            ST_TICK_END:
            begin
                if (!sts.pend_valid)
                    state_next = ST_IDLE;
                else if (sts.out_free)
                begin
                    ctl.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PLAY_CART:
            begin
                ctl.sel_cmd_cart = 1'b1;
                state_next       = ST_PLAY_START;
            end
            ST_PLAY_START:
            begin
                ctl.play_start = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/cvae_datapath.sv
// Voice and cart tables, envelope and gain arithmetic, and the result register.
module cvae_datapath import cvae_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int CART_COUNT  = CART_COUNT_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  dp_cmd_t               ctl,
    output dp_stat_t              sts
);

    localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CART_W  = (CART_COUNT > 1) ? $clog2(CART_COUNT) : 1;
    localparam int CMP_W   = (CART_W > CART_FIELD_W) ? CART_W : CART_FIELD_W;
    localparam int FB1     = FRAME_BITS + 1;

    typedef struct packed {
        phase_t                     phase;
        logic [CART_W-1:0]          cart;
        logic [FRAME_BITS-1:0]      pos;
        logic [ENV_W-1:0]           env;
        logic [ENV_W-1:0]           rstep;
        logic                       ign;
        logic [GAIN_W-1:0]          gnow;
        logic signed [GSTEP_W-1:0]  gstep;
        logic [GCD_W-1:0]           gcd;
        logic [GAIN_W-1:0]          gtgt;
    } voice_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] len;
        logic                  loop;
        logic [GAIN_W-1:0]     gain;
    } cart_t;

    // Configuration registers
    logic [ENV_W-1:0] env_step_reg;
    logic [RF_W-1:0]  rel_frames_reg;
    logic [GCD_W-1:0] ramp_frames_reg;

    // Latched command item
    logic [CMD_W-1:0]        l_cmd_reg;
    logic [CART_FIELD_W-1:0] l_cart_reg;
    logic                    l_ign_reg;
    logic [LEN_FIELD_W-1:0]  l_len_reg;
    logic                    l_loop_reg;
    logic [GAIN_W-1:0]       l_gain_reg;

    // Tables
    voice_t voice_mem [VOICE_COUNT];
    cart_t  cart_mem  [CART_COUNT];
    voice_t vrd_reg;
    cart_t  crd_raw_reg;
    logic   crd_vld_reg;
    logic [VOICE_COUNT-1:0] active_reg;
    logic [CART_COUNT-1:0]  cart_vld_reg;

    // Walk state
    logic [VOICE_W-1:0] idx_reg;
    logic               found_reg;
    logic [VOICE_W-1:0] first_reg;
    logic [N_W-1:0]     n_reg;

    // Working copy of the voice under evaluation
    voice_t                work_reg, work_next;
    logic                  w_retire_reg, w_retire_next;
    logic                  w_fade_reg, w_fade_next;
    logic                  w_gdiv_reg, w_gdiv_next;
    logic                  w_gneg_reg, w_gneg_next;
    logic [DIV_W-1:0]      w_gdiff_reg, w_gdiff_next;
    logic [FRAME_BITS-1:0] w_left_reg, w_left_next;
    logic [GAIN_W-1:0]     gout_reg, gout_next;
    logic [PROD_W-1:0]     prod_reg;

    // Pending and output results
    logic                     pend_valid_reg;
    logic [VOICE_FIELD_W-1:0] pend_voice_reg;
    logic [CART_FIELD_W-1:0]  pend_cart_reg;
    logic [POS_FIELD_W-1:0]   pend_pos_reg;
    logic [WEIGHT_W-1:0]      pend_wt_reg;
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;
    logic                     out_last_reg;

    // Divider
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;
    logic [DIV_W-1:0]      div_dividend;
    logic [FRAME_BITS-1:0] div_divisor;

    // Misc combinational
    cart_t                 crd;
    logic                  cart_ok;
    logic [CART_W-1:0]     cmd_cart_addr;
    logic [CART_W-1:0]     cart_raddr;
    logic                  loop_eff;
    logic                  rel_hit;
    logic                  cart_match;
    logic                  report;
    logic                  do_emit;
    logic                  push;
    logic                  out_free;
    logic                  start_ok;
    logic                  vm_we;
    logic [VOICE_W-1:0]    vm_waddr;
    voice_t                vm_wdata;
    voice_t                rel_entry;
    voice_t                start_entry;
    voice_t                wb_entry;
    logic [WEIGHT_W-1:0]   weight;
    logic [M_TDATA_USED_W-1:0] result_bits;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_step_reg    <= ENVELOPE_STEP_RST;
            rel_frames_reg  <= RELEASE_FRAMES_RST;
            ramp_frames_reg <= GAIN_RAMP_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENVELOPE_STEP:    env_step_reg    <= cfg_wdata[ENV_W-1:0];
                REG_RELEASE_FRAMES:   rel_frames_reg  <= cfg_wdata[RF_W-1:0];
                REG_GAIN_RAMP_FRAMES: ramp_frames_reg <= cfg_wdata[GCD_W-1:0];
                default:              ramp_frames_reg <= ramp_frames_reg;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            l_cmd_reg  <= s_tuser;
            l_cart_reg <= s_tdata[5:0];
            l_ign_reg  <= s_tdata[6];
            l_len_reg  <= s_tdata[30:7];
            l_loop_reg <= s_tdata[31];
            l_gain_reg <= s_tdata[55:32];
        end
    end

    assign cart_ok       = 32'(l_cart_reg) < CART_COUNT;
    assign cmd_cart_addr = CART_W'(l_cart_reg);
    assign cart_raddr    = ctl.sel_cmd_cart ? cmd_cart_addr : vrd_reg.cart;

    // Cart entries not yet written read as unloaded with unity gain
    always_comb
    begin
        if (crd_vld_reg)
            crd = crd_raw_reg;
        else
        begin
            crd.len  = '0;
            crd.loop = 1'b0;
            crd.gain = GAIN_ONE;
        end
    end

    // Table memories with registered reads
    always_ff @(posedge clk)
    begin
        if (vm_we)
            voice_mem[vm_waddr] <= vm_wdata;
        vrd_reg <= voice_mem[idx_reg];
        if (ctl.set_cart)
            cart_mem[cmd_cart_addr] <= '{len: FRAME_BITS'(l_len_reg), loop: l_loop_reg,
                                         gain: l_gain_reg};
        crd_raw_reg <= cart_mem[cart_raddr];
        crd_vld_reg <= cart_vld_reg[cart_raddr];
    end

    // Voice activity, cart valid bits, walk index and result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            cart_vld_reg <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            n_reg        <= '0;
        end
        else
        begin
            if (ctl.flush)
                active_reg <= '0;
            if (ctl.retire)
                active_reg[idx_reg] <= 1'b0;
            if (ctl.play_start && start_ok)
                active_reg[first_reg] <= 1'b1;
            if (ctl.set_cart)
                cart_vld_reg[cmd_cart_addr] <= 1'b1;
            if (ctl.idx_clr)
                idx_reg <= '0;
            else if (ctl.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (ctl.take)
                found_reg <= 1'b0;
            else if (ctl.vscan && !active_reg[idx_reg])
                found_reg <= 1'b1;
            if (ctl.tick_clr)
                n_reg <= '0;
            else if (do_emit)
                n_reg <= n_reg + 1'b1;
        end
    end

    // Remember the first idle voice of the walk
    always_ff @(posedge clk)
    begin
        if (ctl.vscan && !active_reg[idx_reg] && !found_reg)
            first_reg <= idx_reg;
    end

    // Release decision for play, stop and stop all
    assign cart_match = CMP_W'(vrd_reg.cart) == CMP_W'(l_cart_reg);
    always_comb
    begin
        unique case (cmd_code_t'(l_cmd_reg))
            CMD_PLAY:     rel_hit = cart_match || !crd.loop || vrd_reg.ign;
            CMD_STOP:     rel_hit = cart_match;
            CMD_STOP_ALL: rel_hit = 1'b1;
            default:      rel_hit = 1'b0;
        endcase
    end

    // Working copy update: evaluation, fade and gain quotients, envelope step
    always_comb
    begin
        logic                   pos_ge;
        logic [FRAME_BITS-1:0]  pos1;
        logic [FB1-1:0]         fade_sum;
        logic                   gchg;
        logic signed [GSTEP_W-1:0] gdiff;
        logic [GSTEP_W-1:0]     gmag;
        logic [ENV_W:0]         att_sum;
        logic [ENV_W-1:0]       qcut;
        logic [GSTEP_W-1:0]     gq;
        logic [GAIN_W-1:0]      gadd;

        work_next     = work_reg;
        w_retire_next = w_retire_reg;
        w_fade_next   = w_fade_reg;
        w_gdiv_next   = w_gdiv_reg;
        w_gneg_next   = w_gneg_reg;
        w_gdiff_next  = w_gdiff_reg;
        w_left_next   = w_left_reg;
        gout_next     = gout_reg;

        loop_eff = crd.loop && !vrd_reg.ign;
        pos_ge   = vrd_reg.pos >= crd.len;
        pos1     = pos_ge ? '0 : vrd_reg.pos;
        fade_sum = {1'b0, pos1} + FB1'(rel_frames_reg);
        gchg     = crd.gain != vrd_reg.gtgt;
        gdiff    = $signed({1'b0, crd.gain}) - $signed({1'b0, vrd_reg.gnow});
        gmag     = gdiff[GSTEP_W-1] ? GSTEP_W'(-gdiff) : GSTEP_W'(gdiff);
        att_sum  = {1'b0, work_reg.env} + {1'b0, env_step_reg};
        qcut     = div_quo;
        gq       = {1'b0, div_quo};
        gadd     = GAIN_W'({1'b0, work_reg.gnow} + work_reg.gstep);

        if (ctl.eval)
        begin
            work_next     = vrd_reg;
            work_next.pos = pos1;
            w_retire_next = pos_ge && (!loop_eff || crd.len == '0);
            w_fade_next   = !loop_eff && vrd_reg.phase != PH_RELEASE &&
                            fade_sum >= {1'b0, crd.len};
            if (w_fade_next)
                work_next.phase = PH_RELEASE;
            w_left_next   = crd.len - pos1;
            w_gneg_next   = gdiff[GSTEP_W-1];
            w_gdiff_next  = gmag[DIV_W-1:0];
            w_gdiv_next   = 1'b0;
            if (gchg)
            begin
                work_next.gtgt = crd.gain;
                if (ramp_frames_reg == '0)
                begin
                    work_next.gnow  = crd.gain;
                    work_next.gcd   = '0;
                    work_next.gstep = '0;
                end
                else
                begin
                    work_next.gcd = ramp_frames_reg;
                    w_gdiv_next   = 1'b1;
                end
            end
        end
        if (ctl.fade_done)
            work_next.rstep = (qcut > env_step_reg) ? qcut : env_step_reg;
        if (ctl.gain_done)
            work_next.gstep = w_gneg_reg ? $signed(-gq) : $signed(gq);
        if (ctl.env_step)
        begin
            // advance attack or release
            if (work_reg.phase == PH_ATTACK)
            begin
                if (att_sum >= {1'b0, ENV_ONE})
                begin
                    work_next.env   = ENV_ONE;
                    work_next.phase = PH_SUSTAIN;
                end
                else
                    work_next.env = att_sum[ENV_W-1:0];
            end
            else if (work_reg.phase == PH_RELEASE)
                work_next.env = work_reg.env - work_reg.rstep;
            // advance the gain ramp
            if (work_reg.gcd == '0)
                gout_next = work_reg.gtgt;
            else
            begin
                work_next.gcd = work_reg.gcd - 1'b1;
                if (work_reg.gcd == GCD_W'(1))
                    work_next.gnow = work_reg.gtgt;
                else
                    work_next.gnow = gadd;
                gout_next = work_next.gnow;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        w_retire_reg <= w_retire_next;
        w_fade_reg   <= w_fade_next;
        w_gdiv_reg   <= w_gdiv_next;
        w_gneg_reg   <= w_gneg_next;
        w_gdiff_reg  <= w_gdiff_next;
        w_left_reg   <= w_left_next;
        gout_reg     <= gout_next;
        if (ctl.mul)
            prod_reg <= work_reg.env * gout_reg;
    end

    // Shared divider: fade quotient or gain step
    assign div_dividend = ctl.fade_start ? work_reg.env : w_gdiff_reg;
    assign div_divisor  = ctl.fade_start ? w_left_reg : FRAME_BITS'(ramp_frames_reg);

    cvae_div #(
        .DIVISOR_W(FRAME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.fade_start || ctl.gain_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Voice table write port
    always_comb
    begin
        rel_entry       = vrd_reg;
        rel_entry.phase = PH_RELEASE;
        rel_entry.rstep = env_step_reg;

        wb_entry     = work_reg;
        wb_entry.pos = work_reg.pos + 1'b1;

        start_entry.phase = PH_ATTACK;
        start_entry.cart  = cmd_cart_addr;
        start_entry.pos   = '0;
        start_entry.env   = '0;
        start_entry.rstep = env_step_reg;
        start_entry.ign   = l_ign_reg;
        start_entry.gnow  = crd.gain;
        start_entry.gstep = '0;
        start_entry.gcd   = '0;
        start_entry.gtgt  = crd.gain;

        start_ok = found_reg && crd.len != '0;
        vm_we    = ctl.rel_write || ctl.writeback || (ctl.play_start && start_ok);
        vm_waddr = ctl.play_start ? first_reg : idx_reg;
        priority if (ctl.play_start)
            vm_wdata = start_entry;
        else if (ctl.rel_write)
            vm_wdata = rel_entry;
        else
            vm_wdata = wb_entry;
    end

    // Saturate envelope times gain to Q4.20
    assign weight = (prod_reg[PROD_W-1:ENV_FRAC] > {1'b0, {WEIGHT_W{1'b1}}}) ?
                    {WEIGHT_W{1'b1}} : prod_reg[ENV_FRAC+WEIGHT_W-1:ENV_FRAC];

    assign report   = n_reg < MAX_REPORTS;
    assign do_emit  = ctl.emit && report;
    assign out_free = !out_valid_reg || m_tready;
    assign push     = (do_emit && pend_valid_reg) || ctl.out_last;
    assign result_bits = {pend_wt_reg, pend_pos_reg, pend_cart_reg, pend_voice_reg};

    // Result slots: one pending, one on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (do_emit)
                pend_valid_reg <= 1'b1;
            else if (ctl.out_last)
                pend_valid_reg <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= M_TDATA_W'(result_bits);
            out_last_reg <= ctl.out_last;
        end
        if (do_emit)
        begin
            pend_voice_reg <= VOICE_FIELD_W'(idx_reg);
            pend_cart_reg  <= CART_FIELD_W'(work_reg.cart);
            pend_pos_reg   <= POS_FIELD_W'(work_reg.pos);
            pend_wt_reg    <= weight;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    always_comb
    begin
        sts.cmd        = cmd_code_t'(l_cmd_reg);
        sts.cart_ok    = cart_ok;
        sts.active_cur = active_reg[idx_reg];
        sts.idx_last   = idx_reg == VOICE_W'(VOICE_COUNT - 1);
        sts.rel_hit    = rel_hit;
        sts.w_retire   = w_retire_reg;
        sts.w_fade     = w_fade_reg;
        sts.w_gdiv     = w_gdiv_reg;
        sts.env_retire = work_reg.phase == PH_RELEASE && work_reg.env <= work_reg.rstep;
        sts.div_done   = div_done;
        sts.emit_ok    = !report || !pend_valid_reg || out_free;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

endmodule

// File: hw/rtl/cart_voice_allocator_envelope_unit.sv
// Top level of the cart voice allocator with envelope and gain smoothing.
//
// Commands arrive on the s_axis stream (tuser = command code, tdata = cart,
// ignore_loop, new_length, new_loop, new_gain). A tick walks every voice in
// index order and sends one m_axis transfer per sounding voice, at most
// MAX_REPORTS per tick, with tlast on the final one of the tick; play, stop,
// stop all, flush and set cart send nothing. One command is taken at a time:
// s_axis_tready is high only while the sequencer is idle. A tick runs the
// shared bit-serial divider for each division it needs (entering the end
// fade, or a cart gain change with a nonzero ramp) and waits for it. The walk
// goes through the single voice table read and write port once per voice.
// The registers take effect from cfg_we writes; the user must write them only
// while no command runs, as the block itself does not enforce this.
// Reset clears all voices to idle, all carts to unloaded with unity gain and
// loads the register defaults; no clearing pass is needed. When m_axis_tready
// is low, one result waits in the output register and one more in a pending
// slot; the walk then stalls until the output register drains.
module cart_voice_allocator_envelope_unit import cvae_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int CART_COUNT  = CART_COUNT_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cart[5:0], ignore_loop[6], new_length[30:7], new_loop[31], new_gain[55:32]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[2:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // voice[5:0], source_cart[11:6], frame_position[35:12], weight[59:36], zero[63:60]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    dp_cmd_t  ctl;
    dp_stat_t sts;

    cvae_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .ctl     (ctl)
    );

    cvae_datapath #(
        .VOICE_COUNT (VOICE_COUNT),
        .CART_COUNT  (CART_COUNT),
        .FRAME_BITS  (FRAME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
